/* design/ffha_pkg.sv */
// Shared constants and types of the first-fit heap allocator.
package ffha_pkg;

    localparam int WORD_W  = 16;
    localparam int FIELD_W = 10;
    localparam int PTR_W   = WORD_W + 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [WORD_W-1:0] TAG_FREE = 16'd1;
    localparam logic [WORD_W-1:0] TAG_USED = 16'd2;
    localparam logic [WORD_W-1:0] TAG_END  = 16'd3;
    localparam logic [WORD_W-1:0] HDR      = 16'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [PADDR_W-3:0] REG_POOL_SIZE = 1'b0;

    localparam logic [FIELD_W-1:0] POOL_RESET = 10'd1021;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MERGE = 2'd2
    } t_op;

endpackage

/* design/ffha_req_if.sv */
// Request channel interface of the first-fit heap allocator.
interface ffha_req_if;
    import ffha_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic [FIELD_W-1:0] req_words;
    logic [FIELD_W-1:0] block_addr;

    modport source (output valid, output func, output req_words, output block_addr,
                    input ready);
    modport sink   (input valid, input func, input req_words, input block_addr,
                    output ready);
endinterface

/* design/ffha_rsp_if.sv */
// Response channel interface of the first-fit heap allocator.
interface ffha_rsp_if;
    import ffha_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] addr;
    logic               status;

    modport source (output valid, output addr, output status, input ready);
    modport sink   (input valid, input addr, input status, output ready);
endinterface

/* design/first_fit_heap_allocator_unit.sv */
// First-fit heap allocator over a word-addressed implicit block list.
//
//   Channel   Direction  Carries                          Transfer when
//   i_req     in         func, req_words, block_addr      valid && ready
//   o_rsp     out        addr, status                     valid && ready
//   APB       in/out     pool_size register at byte 0     psel && penable && pwrite
//
// A request walks each block header with a tag read, a size read and a decision, then
// makes four header writes for a split grant or one for a whole block, and is accepted
// and hands off its result in states of their own. Freeing a used block walks the list
// again to merge, checking each header and adding in each absorbed neighbor. Reset and
// each pool_size write format the heap: first tag, first size, end mark. A finished
// result waits in the output register, holding off requests, until it leaves.
module first_fit_heap_allocator_unit #(
    parameter int HEAP_WORDS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ffha_req_if.sink                      i_req,
    ffha_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffha_pkg::PADDR_W-1:0]  paddr,
    input  logic [ffha_pkg::PDATA_W-1:0]  pwdata,
    output logic [ffha_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ffha_pkg::*;

    localparam int AW = $clog2(HEAP_WORDS);
    localparam logic [PTR_W-1:0] HEAP_P   = PTR_W'(HEAP_WORDS);
    localparam logic [PTR_W-1:0] MAX_POOL = PTR_W'(HEAP_WORDS - 3);
    localparam logic [PTR_W-1:0] ONE_P    = PTR_W'(1);
    localparam logic [PTR_W-1:0] HDR_P    = PTR_W'(HDR);

    // Steps of the header rewrite that closes an allocation.
    localparam logic [1:0] STEP_REM_TAG  = 2'd0;
    localparam logic [1:0] STEP_REM_SIZE = 2'd1;
    localparam logic [1:0] STEP_SIZE     = 2'd2;
    localparam logic [1:0] STEP_TAG      = 2'd3;

    typedef enum logic [11:0] {
        S_FMT0   = 12'b0000_0000_0001,
        S_FMT1   = 12'b0000_0000_0010,
        S_FMT2   = 12'b0000_0000_0100,
        S_IDLE   = 12'b0000_0000_1000,
        S_TAG    = 12'b0000_0001_0000,
        S_SIZE   = 12'b0000_0010_0000,
        S_DECIDE = 12'b0000_0100_0000,
        S_SPLIT  = 12'b0000_1000_0000,
        S_MTAG   = 12'b0001_0000_0000,
        S_MSIZE  = 12'b0010_0000_0000,
        S_MADD   = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    logic [WORD_W-1:0] r_mem [HEAP_WORDS];
    logic [WORD_W-1:0] r_rdata;

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [PTR_W-1:0]   r_i, n_i;
    logic [PTR_W-1:0]   r_n, n_n;
    logic [WORD_W-1:0]  r_size, n_size;
    logic [WORD_W-1:0]  r_tag, n_tag;
    logic [FIELD_W-1:0] r_req, n_req;
    logic [FIELD_W-1:0] r_baddr, n_baddr;
    logic [1:0]         r_step, n_step;
    logic [FIELD_W-1:0] r_res_addr, n_res_addr;
    logic               r_res_status, n_res_status;
    logic               r_out_valid, n_out_valid;
    logic [FIELD_W-1:0] r_out_addr, n_out_addr;
    logic               r_out_status, n_out_status;
    logic [FIELD_W-1:0] r_pool;

    logic              cfg_wr;
    logic              in_fire;
    logic [PTR_W-1:0]  pool_clamped;
    logic [AW-1:0]     rd_addr;
    logic              we;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [PTR_W-1:0]  add_a;
    logic [WORD_W-1:0] add_b;
    logic [PTR_W-1:0]  add_sum;
    logic              tag_is_block;

    // The configuration port never stalls; a write reformats the heap.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1:2] == REG_POOL_SIZE);
    assign prdata  = (paddr[PADDR_W-1:2] == REG_POOL_SIZE) ?
                     PDATA_W'(r_pool) : '0;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.addr   = r_out_addr;
    assign o_rsp.status = r_out_status;

    // A pool that would push the end mark past the heap is clamped.
    assign pool_clamped = (PTR_W'(r_pool) > MAX_POOL) ? MAX_POOL : PTR_W'(r_pool);

    // The shared header adder: base plus header length plus a size.
    assign add_sum = add_a + HDR_P + PTR_W'(add_b);

    assign tag_is_block = (r_rdata == TAG_FREE) || (r_rdata == TAG_USED);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_i          = r_i;
        n_n          = r_n;
        n_size       = r_size;
        n_tag        = r_tag;
        n_req        = r_req;
        n_baddr      = r_baddr;
        n_step       = r_step;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        rd_addr      = r_i[AW-1:0];
        we           = 1'b0;
        wr_addr      = r_i[AW-1:0];
        wr_data      = TAG_FREE;
        add_a        = r_i;
        add_b        = r_size;

        unique case (r_state)
            S_FMT0: begin
                we      = 1'b1;
                wr_addr = '0;
                wr_data = TAG_FREE;
                n_state = S_FMT1;
            end
            S_FMT1: begin
                we      = 1'b1;
                wr_addr = AW'(1);
                wr_data = pool_clamped[WORD_W-1:0];
                n_state = S_FMT2;
            end
            S_FMT2: begin
                we      = 1'b1;
                wr_addr = AW'(pool_clamped + HDR_P);
                wr_data = TAG_END;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_op    = (i_req.func == FUNC_FREE) ? OP_FREE : OP_ALLOC;
                    n_req   = i_req.req_words;
                    n_baddr = i_req.block_addr;
                    n_i     = '0;
                    n_state = S_TAG;
                end
            end
            S_TAG: begin
                // Stop at the heap's end or, for a free, once past the target.
                if ((r_i + ONE_P) >= HEAP_P ||
                    (r_op == OP_FREE && (r_i + HDR_P) > PTR_W'(r_baddr))) begin
                    n_res_addr   = '0;
                    n_res_status = (r_op == OP_ALLOC);
                    n_state      = S_DONE;
                end else begin
                    rd_addr = r_i[AW-1:0];
                    n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                rd_addr = AW'(r_i + ONE_P);
                n_tag   = r_rdata;
                if (!tag_is_block) begin
                    n_res_addr   = '0;
                    n_res_status = (r_op == OP_ALLOC);
                    n_state      = S_DONE;
                end else if (r_op == OP_FREE && (r_i + HDR_P) == PTR_W'(r_baddr)) begin
                    if (r_rdata == TAG_USED) begin
                        we      = 1'b1;
                        wr_addr = r_i[AW-1:0];
                        wr_data = TAG_FREE;
                        n_op    = OP_MERGE;
                        n_i     = '0;
                        n_state = S_TAG;
                    end else begin
                        n_res_addr   = '0;
                        n_res_status = 1'b0;
                        n_state      = S_DONE;
                    end
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                add_b = r_rdata;
                case (r_op)
                    OP_ALLOC: begin
                        if (r_tag == TAG_FREE && r_rdata >= WORD_W'(r_req)) begin
                            n_size  = r_rdata;
                            n_step  = ((17'(r_req) + 17'(HDR)) <= 17'(r_rdata)) ?
                                      STEP_REM_TAG : STEP_TAG;
                            n_state = S_SPLIT;
                        end else begin
                            n_i     = add_sum;
                            n_state = S_TAG;
                        end
                    end
                    OP_MERGE: begin
                        if (r_tag == TAG_FREE) begin
                            n_size  = r_rdata;
                            n_state = S_MTAG;
                        end else begin
                            n_i     = add_sum;
                            n_state = S_TAG;
                        end
                    end
                    default: begin
                        n_i     = add_sum;
                        n_state = S_TAG;
                    end
                endcase
            end
            S_SPLIT: begin
                we     = 1'b1;
                n_step = r_step + 2'd1;
                case (r_step)
                    STEP_REM_TAG: begin
                        add_b   = WORD_W'(r_req);
                        wr_addr = add_sum[AW-1:0];
                        wr_data = TAG_FREE;
                        n_n     = add_sum;
                    end
                    STEP_REM_SIZE: begin
                        wr_addr = AW'(r_n + ONE_P);
                        wr_data = r_size - WORD_W'(r_req) - HDR;
                    end
                    STEP_SIZE: begin
                        wr_addr = AW'(r_i + ONE_P);
                        wr_data = WORD_W'(r_req);
                    end
                    default: begin
                        wr_addr      = r_i[AW-1:0];
                        wr_data      = TAG_USED;
                        n_res_addr   = FIELD_W'(r_i + HDR_P);
                        n_res_status = 1'b0;
                        n_state      = S_DONE;
                    end
                endcase
            end
            S_MTAG: begin
                // add_sum is the header right after the growing free block.
                if ((add_sum + ONE_P) >= HEAP_P) begin
                    we      = 1'b1;
                    wr_addr = AW'(r_i + ONE_P);
                    wr_data = r_size;
                    n_i     = add_sum;
                    n_state = S_TAG;
                end else begin
                    rd_addr = add_sum[AW-1:0];
                    n_n     = add_sum;
                    n_state = S_MSIZE;
                end
            end
            S_MSIZE: begin
                if (r_rdata == TAG_FREE) begin
                    rd_addr = AW'(r_n + ONE_P);
                    n_state = S_MADD;
                end else begin
                    we      = 1'b1;
                    wr_addr = AW'(r_i + ONE_P);
                    wr_data = r_size;
                    n_i     = r_n;
                    n_state = S_TAG;
                end
            end
            S_MADD: begin
                add_a   = PTR_W'(r_size);
                add_b   = r_rdata;
                n_size  = add_sum[WORD_W-1:0];
                n_state = S_MTAG;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_wr) begin
            n_state = S_FMT0;
        end
    end

    // The output register loads from S_DONE once its previous result has left.
    always_comb begin
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        if (r_state == S_DONE && (!r_out_valid || o_rsp.ready)) begin
            n_out_valid  = 1'b1;
            n_out_addr   = r_res_addr;
            n_out_status = r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FMT0;
            r_out_valid <= 1'b0;
            r_pool      <= POOL_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_pool <= pwdata[FIELD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_i          <= n_i;
        r_n          <= n_n;
        r_size       <= n_size;
        r_tag        <= n_tag;
        r_req        <= n_req;
        r_baddr      <= n_baddr;
        r_step       <= n_step;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

`ifndef SYNTHESIS
    // A request starts a walk, so the block stops taking requests at once.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_req.ready)
        else $error("request accepted while a walk was still starting");

    // A pool size write always restarts the format sequence.
    a_cfg_reformats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_state == S_FMT0))
        else $error("pool size write did not reformat the heap");

    // Header rewrites only happen for a block whose header lies inside the heap.
    a_split_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> ((r_i + ONE_P) < HEAP_P))
        else $error("allocation rewrite outside the heap");

    // A failed allocation never carries an address.
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status) |-> (o_rsp.addr == '0))
        else $error("no-fit result with a nonzero address");
`endif

endmodule
